// File: rtl/core/dnsrre_pkg.sv
`timescale 1ns / 1ps

package dnsrre_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_PARSE  = 2'd1;
  localparam logic [1:0] OP_EXPAND = 2'd2;

  // Record kinds of a result.
  localparam logic [2:0] KIND_ANSWER_A  = 3'd0;
  localparam logic [2:0] KIND_NS        = 3'd1;
  localparam logic [2:0] KIND_GLUE_A    = 3'd2;
  localparam logic [2:0] KIND_CNAME     = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_DROPPED   = 2'd3;

  // DNS record types of interest.
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_NS    = 16'd2;
  localparam logic [15:0] TYPE_CNAME = 16'd5;

  // Width of the walk offset; covers an rdata start plus a 16-bit rdata length.
  localparam int OFF_W = 18;
  // Width of the name offset fields.
  localparam int NOFF_W = 9;
  localparam int RESULT_CAP = 48;
  localparam int HEADER_BYTES = 12;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

endpackage

// File: rtl/core/dns_response_record_extractor.sv
`timescale 1ns / 1ps

// DNS response record extractor.
// Input channel (item_valid/item_ready) carries one beat per operation: load
// appends byte_value to the packet store (first_byte restarts the packet),
// parse walks the loaded response and expand spells out the name found at
// name_offset. Output channel (result_valid/result_ready) carries the result
// beats, the final one of each operation flagged by last. The register
// jump_limit is written through config_write/config_data; the user must
// write it only while idle, since the block itself does not enforce it. A
// load beat returns nothing. Parse and expand are sequenced through the
// single read port of the packet store, which fetches one byte at a time
// (header, name bytes, record fields). Expand buffers the name text in a
// name memory and reads it back one character at a time. One operation is
// in flight at a time; item_ready is high only while the sequencer is idle.
// Reset clears packet length, overflow flag and all control, and loads the
// jump limit with ten; store contents are undefined until loaded. When the
// receiver stalls, the sequencer waits on the output register, and a new
// item can be accepted while the final result beat still waits there.
module dns_response_record_extractor
  import dnsrre_pkg::*;
#(
  parameter int MAX_PACKET     = 512,
  parameter int MAX_NAME_CHARS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                config_write,
  input  logic [3:0]          config_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          operation,
  input  logic [7:0]          byte_value,
  input  logic                first_byte,
  input  logic [NOFF_W-1:0]   name_offset,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [2:0]          record_kind,
  output logic [31:0]         ipv4_address,
  output logic [NOFF_W-1:0]   record_name_offset,
  output logic [63:0]         text_chunk,
  output logic [3:0]          chunk_bytes,
  output logic [1:0]          status,
  output logic                last
);

  localparam int AW = $clog2(MAX_PACKET);
  localparam int LW = $clog2(MAX_PACKET + 1);
  localparam int NW = $clog2(MAX_NAME_CHARS);
  localparam int CW = $clog2(MAX_NAME_CHARS + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_W_LEN   = 5'd1;
  localparam logic [4:0] S_W_LEND  = 5'd2;
  localparam logic [4:0] S_W_PTR   = 5'd3;
  localparam logic [4:0] S_W_CRD   = 5'd4;
  localparam logic [4:0] S_W_CWR   = 5'd5;
  localparam logic [4:0] S_P_HDR   = 5'd6;
  localparam logic [4:0] S_P_HDRD  = 5'd7;
  localparam logic [4:0] S_P_Q     = 5'd8;
  localparam logic [4:0] S_P_QA    = 5'd9;
  localparam logic [4:0] S_P_REC   = 5'd10;
  localparam logic [4:0] S_P_R1    = 5'd11;
  localparam logic [4:0] S_P_FRD   = 5'd12;
  localparam logic [4:0] S_P_FRDD  = 5'd13;
  localparam logic [4:0] S_P_DEC   = 5'd14;
  localparam logic [4:0] S_P_IPRD  = 5'd15;
  localparam logic [4:0] S_P_IPRDD = 5'd16;
  localparam logic [4:0] S_P_IPE   = 5'd17;
  localparam logic [4:0] S_P_PUSH  = 5'd18;
  localparam logic [4:0] S_P_FIN   = 5'd19;
  localparam logic [4:0] S_E_ST    = 5'd20;
  localparam logic [4:0] S_E_RD    = 5'd21;
  localparam logic [4:0] S_E_RDD   = 5'd22;
  localparam logic [4:0] S_E_OUT   = 5'd23;

  // Memories.
  logic [7:0] packet_store [MAX_PACKET];
  logic [7:0] name_text [MAX_NAME_CHARS];
  logic [7:0] prd;
  logic [7:0] trd;
  logic [OFF_W-1:0] p_raddr;
  logic       p_we;
  logic       t_we;
  logic [7:0] t_wdata;

  // Control and walk state.
  logic [4:0]        state;
  logic [4:0]        wret;
  logic              is_expand;
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  back;
  logic [4:0]        hops;
  logic              jumped;
  logic              any;
  logic [7:0]        lbyte;
  logic [7:0]        lcnt;
  logic [LW-1:0]     length;
  logic              overflow;
  logic [3:0]        jump_limit;

  // Parse state.
  logic [63:0]       hdr;
  logic [2:0]        h;
  logic [15:0]       qi;
  logic [1:0]        sec;
  logic [5:0]        nres;
  logic [31:0]       acc;
  logic [1:0]        fidx;
  logic [15:0]       rdlen;
  logic [NOFF_W-1:0] owner;
  logic [2:0]        pend_kind;
  logic [31:0]       pend_ip;
  logic [NOFF_W-1:0] pend_noff;
  logic              hold_valid;
  logic [2:0]        hold_kind;
  logic [31:0]       hold_ip;
  logic [NOFF_W-1:0] hold_noff;
  logic [1:0]        hold_status;

  // Expand state.
  logic [NOFF_W-1:0] name_start;
  logic [CW-1:0]     tn;
  logic [CW-1:0]     tk;
  logic              trunc;
  logic [63:0]       chunk;
  logic [3:0]        ccnt;
  logic [1:0]        est;

  logic [OFF_W-1:0]  lenx;
  logic [1:0]        pst;
  logic [15:0]       sec_count;
  logic [OFF_W-1:0]  rd_start;
  logic [OFF_W-1:0]  label_end;
  logic              is_label;
  logic              out_free;
  logic              beat_load;
  logic [OFF_W-1:0]  walk_back2;
  logic [LW-1:0]     load_len;

  assign lenx      = OFF_W'(length);
  assign pst       = overflow ? ST_DROPPED : ST_OK;
  assign rd_start  = off + OFF_W'(10);
  assign label_end = off + OFF_W'(1) + OFF_W'(prd);
  assign is_label  = (prd[7:6] != 2'b11) && (prd != 8'd0);
  assign out_free  = !result_valid || result_ready;
  // High when the output register takes a new beat this cycle.
  assign beat_load = out_free && (((state == S_P_PUSH) && hold_valid) ||
                                  (state == S_P_FIN) || (state == S_E_OUT));
  assign walk_back2 = jumped ? back : off + OFF_W'(2);
  assign load_len  = first_byte ? '0 : length;
  assign item_ready = (state == S_IDLE);

  always_comb begin
    case (sec)
      2'd0:    sec_count = hdr[47:32];
      2'd1:    sec_count = hdr[31:16];
      default: sec_count = hdr[15:0];
    endcase
  end

  always_comb begin
    case (state)
      S_W_LEND: p_raddr = off + OFF_W'(1);
      S_P_HDR:  p_raddr = OFF_W'(4) + OFF_W'(h);
      S_P_FRD:  p_raddr = off + OFF_W'({fidx[1], 2'b00, fidx[0]});
      S_P_IPRD: p_raddr = rd_start + OFF_W'(fidx);
      default:  p_raddr = off;
    endcase
  end

  assign p_we = item_valid && item_ready && (operation == OP_LOAD) &&
                (load_len < LW'(MAX_PACKET));

  always_comb begin
    t_we    = 1'b0;
    t_wdata = prd;
    if (is_expand && (tn < CW'(MAX_NAME_CHARS))) begin
      if (state == S_W_LEND && is_label && any) begin
        t_we    = 1'b1;
        t_wdata = DOT_CHAR;
      end else if (state == S_W_CWR) begin
        t_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      packet_store[load_len[AW-1:0]] <= byte_value;
    end
    prd <= packet_store[p_raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      name_text[tn[NW-1:0]] <= t_wdata;
    end
    trd <= name_text[tk[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      length       <= '0;
      overflow     <= 1'b0;
      jump_limit   <= 4'd10;
      result_valid <= 1'b0;
      hold_valid   <= 1'b0;
      nres         <= '0;
    end else begin
      if (config_write) begin
        jump_limit <= config_data;
      end
      if (result_valid && result_ready && !beat_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (operation)
              OP_LOAD: begin
                if (load_len < LW'(MAX_PACKET)) begin
                  length   <= load_len + LW'(1);
                  overflow <= first_byte ? 1'b0 : overflow;
                end else begin
                  length   <= load_len;
                  overflow <= 1'b1;
                end
              end
              OP_PARSE: begin
                is_expand <= 1'b0;
                nres      <= '0;
                if (lenx < OFF_W'(HEADER_BYTES)) begin
                  hold_valid  <= 1'b1;
                  hold_kind   <= KIND_NONE;
                  hold_ip     <= '0;
                  hold_noff   <= '0;
                  hold_status <= ST_SHORT;
                  state       <= S_P_FIN;
                end else begin
                  hold_status <= pst;
                  h           <= '0;
                  state       <= S_P_HDR;
                end
              end
              OP_EXPAND: begin
                is_expand  <= 1'b1;
                name_start <= name_offset;
                off        <= OFF_W'(name_offset);
                tn         <= '0;
                trunc      <= 1'b0;
                hops       <= '0;
                jumped     <= 1'b0;
                any        <= 1'b0;
                wret       <= S_E_ST;
                state      <= S_W_LEN;
              end
              default: begin
              end
            endcase
          end
        end

        // Name walk, shared by parse and expand.
        S_W_LEN: begin
          if (off >= lenx) begin
            off   <= jumped ? back : off;
            state <= wret;
          end else begin
            state <= S_W_LEND;
          end
        end
        S_W_LEND: begin
          lbyte <= prd;
          if (prd[7:6] == 2'b11) begin
            if (off + OFF_W'(1) >= lenx) begin
              off   <= jumped ? back : off;
              state <= wret;
            end else begin
              state <= S_W_PTR;
            end
          end else if (prd == 8'd0) begin
            off   <= jumped ? back : off + OFF_W'(1);
            state <= wret;
          end else begin
            if (is_expand && any) begin
              if (tn < CW'(MAX_NAME_CHARS)) begin
                tn <= tn + CW'(1);
              end else begin
                trunc <= 1'b1;
              end
            end
            if (label_end > lenx) begin
              off   <= jumped ? back : off + OFF_W'(1);
              state <= wret;
            end else begin
              off   <= off + OFF_W'(1);
              lcnt  <= prd;
              state <= S_W_CRD;
            end
          end
        end
        S_W_PTR: begin
          back   <= walk_back2;
          jumped <= 1'b1;
          hops   <= hops + 5'd1;
          if (hops + 5'd1 > {1'b0, jump_limit}) begin
            off   <= walk_back2;
            state <= wret;
          end else begin
            off   <= OFF_W'({lbyte[5:0], prd});
            state <= S_W_LEN;
          end
        end
        S_W_CRD: begin
          state <= S_W_CWR;
        end
        S_W_CWR: begin
          if (is_expand) begin
            if (tn < CW'(MAX_NAME_CHARS)) begin
              tn <= tn + CW'(1);
            end else begin
              trunc <= 1'b1;
            end
          end
          off  <= off + OFF_W'(1);
          lcnt <= lcnt - 8'd1;
          if (lcnt == 8'd1) begin
            any   <= 1'b1;
            state <= S_W_LEN;
          end else begin
            state <= S_W_CRD;
          end
        end

        // Parse sequencer.
        S_P_HDR: begin
          state <= S_P_HDRD;
        end
        S_P_HDRD: begin
          hdr <= {hdr[55:0], prd};
          h   <= h + 3'd1;
          if (h == 3'd7) begin
            off   <= OFF_W'(HEADER_BYTES);
            qi    <= '0;
            state <= S_P_Q;
          end else begin
            state <= S_P_HDR;
          end
        end
        S_P_Q: begin
          if ((qi < hdr[63:48]) && (off < lenx)) begin
            hops   <= '0;
            jumped <= 1'b0;
            any    <= 1'b0;
            wret   <= S_P_QA;
            state  <= S_W_LEN;
          end else begin
            sec   <= '0;
            qi    <= '0;
            state <= S_P_REC;
          end
        end
        S_P_QA: begin
          off   <= off + OFF_W'(4);
          qi    <= qi + 16'd1;
          state <= S_P_Q;
        end
        S_P_REC: begin
          if (nres == 6'(RESULT_CAP) || sec == 2'd3) begin
            state <= S_P_FIN;
          end else if (qi >= sec_count) begin
            sec <= sec + 2'd1;
            qi  <= '0;
          end else if (off >= lenx) begin
            state <= S_P_FIN;
          end else begin
            owner  <= off[NOFF_W-1:0];
            hops   <= '0;
            jumped <= 1'b0;
            any    <= 1'b0;
            wret   <= S_P_R1;
            state  <= S_W_LEN;
          end
        end
        S_P_R1: begin
          if (rd_start > lenx) begin
            state <= S_P_FIN;
          end else begin
            fidx  <= '0;
            state <= S_P_FRD;
          end
        end
        S_P_FRD: begin
          state <= S_P_FRDD;
        end
        S_P_FRDD: begin
          acc  <= {acc[23:0], prd};
          fidx <= fidx + 2'd1;
          state <= (fidx == 2'd3) ? S_P_DEC : S_P_FRD;
        end
        S_P_DEC: begin
          // acc holds type in the upper half and rdata length in the lower.
          rdlen <= acc[15:0];
          pend_ip <= '0;
          pend_noff <= (rd_start > OFF_W'(511)) ? NOFF_W'(511) : rd_start[NOFF_W-1:0];
          if (acc[31:16] == TYPE_A && acc[15:0] == 16'd4) begin
            if ((rd_start + OFF_W'(4) <= lenx) && (sec != 2'd1)) begin
              fidx  <= '0;
              state <= S_P_IPRD;
            end else begin
              off   <= rd_start + OFF_W'(acc[15:0]);
              qi    <= qi + 16'd1;
              state <= S_P_REC;
            end
          end else begin
            off <= rd_start + OFF_W'(acc[15:0]);
            qi  <= qi + 16'd1;
            if (acc[31:16] == TYPE_NS && sec == 2'd1) begin
              pend_kind <= KIND_NS;
              state     <= S_P_PUSH;
            end else if (acc[31:16] == TYPE_CNAME && sec == 2'd0) begin
              pend_kind <= KIND_CNAME;
              state     <= S_P_PUSH;
            end else begin
              state <= S_P_REC;
            end
          end
        end
        S_P_IPRD: begin
          state <= S_P_IPRDD;
        end
        S_P_IPRDD: begin
          acc  <= {acc[23:0], prd};
          fidx <= fidx + 2'd1;
          state <= (fidx == 2'd3) ? S_P_IPE : S_P_IPRD;
        end
        S_P_IPE: begin
          pend_ip   <= acc;
          pend_kind <= (sec == 2'd0) ? KIND_ANSWER_A : KIND_GLUE_A;
          pend_noff <= (sec == 2'd0) ? '0 : owner;
          off       <= rd_start + OFF_W'(rdlen);
          qi        <= qi + 16'd1;
          state     <= S_P_PUSH;
        end
        S_P_PUSH: begin
          // The newest result is held back until the next one or the end
          // of the run shows whether it is the last.
          if (out_free) begin
            if (hold_valid) begin
              result_valid       <= 1'b1;
              record_kind        <= hold_kind;
              ipv4_address       <= hold_ip;
              record_name_offset <= hold_noff;
              text_chunk         <= '0;
              chunk_bytes        <= '0;
              status             <= hold_status;
              last               <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_kind  <= pend_kind;
            hold_ip    <= pend_ip;
            hold_noff  <= pend_noff;
            nres       <= nres + 6'd1;
            state      <= S_P_REC;
          end
        end
        S_P_FIN: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            record_kind        <= hold_valid ? hold_kind : KIND_NONE;
            ipv4_address       <= hold_valid ? hold_ip : '0;
            record_name_offset <= hold_valid ? hold_noff : '0;
            text_chunk         <= '0;
            chunk_bytes        <= '0;
            status             <= hold_status;
            last               <= 1'b1;
            hold_valid         <= 1'b0;
            state              <= S_IDLE;
          end
        end

        // Expand output sequencer.
        S_E_ST: begin
          est   <= trunc ? ST_TRUNCATED : pst;
          tk    <= '0;
          ccnt  <= '0;
          chunk <= '0;
          state <= S_E_RD;
        end
        S_E_RD: begin
          state <= ((ccnt < 4'd8) && (tk < tn)) ? S_E_RDD : S_E_OUT;
        end
        S_E_RDD: begin
          chunk[{ccnt[2:0], 3'b000} +: 8] <= trd;
          ccnt  <= ccnt + 4'd1;
          tk    <= tk + CW'(1);
          state <= S_E_RD;
        end
        S_E_OUT: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            record_kind        <= KIND_NONE;
            ipv4_address       <= '0;
            record_name_offset <= name_start;
            text_chunk         <= chunk;
            chunk_bytes        <= ccnt;
            status             <= est;
            last               <= (tk >= tn);
            chunk              <= '0;
            ccnt               <= '0;
            state              <= (tk >= tn) ? S_IDLE : S_E_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A held parse result never survives into idle.
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("held result left behind at idle");

  // The result count stays within the cap.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= 6'(RESULT_CAP))
    else $error("result cap exceeded");

  // The packet length never passes the store depth.
  a_len: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(MAX_PACKET))
    else $error("packet length beyond store");

  // The name text count never passes the name buffer.
  a_text: assert property (@(posedge clk) disable iff (rst)
    is_expand && (state != S_IDLE) |-> tn <= CW'(MAX_NAME_CHARS))
    else $error("name text overrun");

  // A chunk being emitted never holds more than eight characters.
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_OUT) |-> (ccnt <= 4'd8))
    else $error("chunk overfilled");

endmodule

// File: tb/dns_record_checker.sv
`timescale 1ns / 1ps

module dns_record_checker
  import dnsrre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic [3:0]  config_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic [8:0]  name_offset,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [2:0]  record_kind,
  input  logic [31:0] ipv4_address,
  input  logic [8:0]  record_name_offset,
  input  logic [63:0] text_chunk,
  input  logic [3:0]  chunk_bytes,
  input  logic [1:0]  status,
  input  logic        last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [8:0]  noff;
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic [1:0]  stat;
    logic        fin;
  } dns_result_t;

  dns_result_t expected_records[$];

  logic [7:0] pkt_mem [512];
  int         pkt_len;
  bit         dropped;
  int         hop_limit;

  // Name text buffer shared by the walk and the expand predictor.
  logic [7:0] name_txt [256];
  int         name_len;
  bit         name_cut;

  assign pending_count = expected_records.size();

  function automatic logic [7:0] pkt_byte(int i);
    if (i < pkt_len && i < 512) return pkt_mem[i];
    return 8'h00;
  endfunction

  function automatic int pkt_word(int i);
    return (int'(pkt_byte(i)) << 8) | int'(pkt_byte(i + 1));
  endfunction

  function automatic void add_char(bit keep, logic [7:0] c);
    if (!keep) return;
    if (name_len < 256) begin
      name_txt[name_len] = c;
      name_len++;
    end else begin
      name_cut = 1;
    end
  endfunction

  // Follows a possibly compressed name; returns the position after it.
  function automatic int follow_name(int start, bit keep);
    int off, back, hops, b;
    bit jumped, any;
    off = start; back = 0; hops = 0; jumped = 0; any = 0;
    forever begin
      if (off >= pkt_len) break;
      b = pkt_byte(off);
      if ((b & 8'hC0) == 8'hC0) begin
        if (off + 1 >= pkt_len) break;
        if (!jumped) back = off + 2;
        off = ((b & 8'h3F) << 8) | pkt_byte(off + 1);
        jumped = 1;
        hops++;
        if (hops > hop_limit) break;
        continue;
      end
      if (b == 0) begin
        if (!jumped) off++;
        break;
      end
      off++;
      if (any) add_char(keep, DOT_CHAR);
      if (off + b > pkt_len) break;
      for (int k = 0; k < b; k++) add_char(keep, pkt_byte(off + k));
      off += b;
      any = 1;
    end
    if (jumped) off = back;
    return off;
  endfunction

  function automatic void push_record(logic [2:0] kind, logic [31:0] addr, int noff,
                                      logic [63:0] chunk, int nb, logic [1:0] st);
    dns_result_t r;
    r.kind = kind; r.addr = addr; r.noff = noff[8:0]; r.chunk = chunk;
    r.nbytes = nb[3:0]; r.stat = st; r.fin = 0;
    expected_records.insert(expected_records.size(), r);
  endfunction

  function automatic void predict_parse();
    int off, qd, nres, owner, rtype, rdlen, rd;
    int counts [3];
    logic [1:0] st;
    st = dropped ? ST_DROPPED : ST_OK;
    nres = 0;
    if (pkt_len < HEADER_BYTES) begin
      push_record(KIND_NONE, 0, 0, 0, 0, ST_SHORT);
      expected_records[$].fin = 1;
      return;
    end
    qd = pkt_word(4);
    counts[0] = pkt_word(6);
    counts[1] = pkt_word(8);
    counts[2] = pkt_word(10);
    off = HEADER_BYTES;
    for (int i = 0; i < qd && off < pkt_len; i++) off = follow_name(off, 0) + 4;
    for (int sec = 0; sec < 3 && nres < RESULT_CAP; sec++) begin
      for (int i = 0; i < counts[sec] && nres < RESULT_CAP; i++) begin
        if (off >= pkt_len) break;
        owner = off;
        off = follow_name(off, 0);
        if (off + 10 > pkt_len) begin
          off = pkt_len;
          continue;
        end
        rtype = pkt_word(off);
        rdlen = pkt_word(off + 8);
        rd = off + 10;
        if (rtype == TYPE_A && rdlen == 4) begin
          if (rd + 4 <= pkt_len && sec != 1) begin
            if (sec == 0)
              push_record(KIND_ANSWER_A, {pkt_byte(rd), pkt_byte(rd + 1),
                          pkt_byte(rd + 2), pkt_byte(rd + 3)}, 0, 0, 0, st);
            else
              push_record(KIND_GLUE_A, {pkt_byte(rd), pkt_byte(rd + 1),
                          pkt_byte(rd + 2), pkt_byte(rd + 3)}, owner, 0, 0, st);
            nres++;
          end
        end else if (rtype == TYPE_NS && sec == 1) begin
          push_record(KIND_NS, 0, rd > 511 ? 511 : rd, 0, 0, st);
          nres++;
        end else if (rtype == TYPE_CNAME && sec == 0) begin
          push_record(KIND_CNAME, 0, rd > 511 ? 511 : rd, 0, 0, st);
          nres++;
        end
        off = rd + rdlen;
      end
    end
    if (nres == 0) push_record(KIND_NONE, 0, 0, 0, 0, st);
    expected_records[$].fin = 1;
  endfunction

  function automatic void predict_expand(int start);
    int k, nres, cnt;
    logic [63:0] chunk;
    logic [1:0] st;
    name_len = 0;
    name_cut = 0;
    void'(follow_name(start, 1));
    st = name_cut ? ST_TRUNCATED : (dropped ? ST_DROPPED : ST_OK);
    k = 0;
    nres = 0;
    do begin
      chunk = 0;
      cnt = 0;
      while (cnt < 8 && k < name_len) begin
        chunk[8*cnt +: 8] = name_txt[k];
        cnt++;
        k++;
      end
      push_record(KIND_NONE, 0, start, chunk, cnt, st);
      nres++;
    end while (k < name_len && nres < RESULT_CAP);
    expected_records[$].fin = 1;
  endfunction

  task automatic compare_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dns_result_t w;
    if (rst) begin
      pkt_len = 0;
      dropped = 0;
      hop_limit = 10;
      fail_count = 0;
      expected_records.delete();
    end else begin
      if (config_write) hop_limit = config_data;
      if (item_valid && item_ready) begin
        case (operation)
          OP_LOAD: begin
            if (first_byte) begin
              pkt_len = 0;
              dropped = 0;
            end
            if (pkt_len < 512) begin
              pkt_mem[pkt_len] = byte_value;
              pkt_len++;
            end else begin
              dropped = 1;
            end
          end
          OP_PARSE:  predict_parse();
          OP_EXPAND: predict_expand(name_offset);
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_records.size() == 0) begin
          $error("Result beat arrived with no expectation pending");
          fail_count++;
        end else begin
          w = expected_records.pop_front();
          compare_field("record_kind", w.kind, record_kind);
          compare_field("ipv4_address", w.addr, ipv4_address);
          compare_field("record_name_offset", w.noff, record_name_offset);
          compare_field("text_chunk", w.chunk, text_chunk);
          compare_field("chunk_bytes", w.nbytes, chunk_bytes);
          compare_field("status", w.stat, status);
          compare_field("last", w.fin, last);
        end
      end
    end
  end

endmodule

// File: tb/tb_dns_response_record_extractor.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the DNS response record extractor. A checker
// module beside the block predicts every result beat and counts failures;
// this module only builds packets, issues parse and expand beats, writes
// the jump limit while the block is idle, and decides pass or fail.
module tb_dns_response_record_extractor;
  import dnsrre_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        config_write = 0;
  logic [3:0]  config_data = 0;
  logic        item_valid = 0;
  logic        item_ready;
  logic [1:0]  operation = OP_LOAD;
  logic [7:0]  byte_value = 0;
  logic        first_byte = 0;
  logic [8:0]  name_offset = 0;
  logic        result_valid;
  logic        result_ready = 0;
  logic [2:0]  record_kind;
  logic [31:0] ipv4_address;
  logic [8:0]  record_name_offset;
  logic [63:0] text_chunk;
  logic [3:0]  chunk_bytes;
  logic [1:0]  status;
  logic        last;
  int          fail_count;
  int          pending_count;

  // Idle rates in percent; changed between phases.
  int send_idle = 13;
  int recv_idle = 49;
  // Forces the receiver to hold off for a long stretch when set.
  bit hold_receiver = 0;
  // Input beats accepted so far.
  int items = 0;

  // Packet under construction before it is streamed in.
  logic [7:0] pkt_bytes [$];

  always #4 clk = ~clk;

  dns_response_record_extractor dut (
    .clk(clk), .rst(rst),
    .config_write(config_write), .config_data(config_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .operation(operation), .byte_value(byte_value), .first_byte(first_byte),
    .name_offset(name_offset),
    .result_valid(result_valid), .result_ready(result_ready),
    .record_kind(record_kind), .ipv4_address(ipv4_address),
    .record_name_offset(record_name_offset), .text_chunk(text_chunk),
    .chunk_bytes(chunk_bytes), .status(status), .last(last)
  );

  dns_record_checker chk (
    .clk(clk), .rst(rst),
    .config_write(config_write), .config_data(config_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .operation(operation), .byte_value(byte_value), .first_byte(first_byte),
    .name_offset(name_offset),
    .result_valid(result_valid), .result_ready(result_ready),
    .record_kind(record_kind), .ipv4_address(ipv4_address),
    .record_name_offset(record_name_offset), .text_chunk(text_chunk),
    .chunk_bytes(chunk_bytes), .status(status), .last(last),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The receiver redraws ready at each falling edge by the current idle rate,
  // unless a long hold-off is in progress.
  always @(negedge clk) begin
    if (rst || hold_receiver) result_ready <= 0;
    else result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Sends one beat: an optional random gap first, then valid held until the
  // handshake. Valid stays high straight into the next beat when no gap falls.
  task automatic send_beat(logic [1:0] op, logic [7:0] bv, logic fb, logic [8:0] noff);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(negedge clk);
    end
    item_valid <= 1;
    operation <= op;
    byte_value <= bv;
    first_byte <= fb;
    name_offset <= noff;
    do @(posedge clk); while (!item_ready);
    items++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    item_valid <= 0;
  endtask

  // Streams the staged packet into the store, first beat restarting it.
  task automatic load_packet();
    foreach (pkt_bytes[i]) send_beat(OP_LOAD, pkt_bytes[i], i == 0, 9'd0);
  endtask

  task automatic put8(logic [7:0] v);
    pkt_bytes.insert(pkt_bytes.size(), v);
  endtask

  task automatic put16(int v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  // Appends a name of a few random labels, sometimes ending in a pointer to
  // an earlier offset so that compression is exercised.
  task automatic put_name(int labels);
    int len;
    for (int l = 0; l < labels; l++) begin
      len = $urandom_range(1, 6);
      put8(8'(len));
      for (int c = 0; c < len; c++) put8(8'($urandom_range(97, 122)));
    end
    if (pkt_bytes.size() > 14 && $urandom_range(2) == 0) begin
      put8(8'hC0);
      put8(8'd12);
    end else begin
      put8(8'd0);
    end
  endtask

  // Builds a mostly well-formed response: header, questions, then records of
  // random types in the three sections; some packets are cut short or noisy.
  task automatic build_response();
    int qd, cnt [3], rtype, rdlen, cut;
    pkt_bytes.delete();
    qd = $urandom_range(0, 2);
    for (int s = 0; s < 3; s++) cnt[s] = $urandom_range(0, 3);
    put16($urandom);
    put16($urandom);
    put16(qd);
    put16(cnt[0]);
    put16(cnt[1]);
    put16(cnt[2]);
    for (int q = 0; q < qd; q++) begin
      put_name($urandom_range(0, 3));
      put16(1);
      put16(1);
    end
    for (int s = 0; s < 3; s++) begin
      for (int r = 0; r < cnt[s]; r++) begin
        if ($urandom_range(1)) begin
          put8(8'hC0);
          put8(8'd12);
        end else begin
          put_name($urandom_range(1, 2));
        end
        case ($urandom_range(4))
          0, 1: rtype = TYPE_A;
          2: rtype = TYPE_NS;
          3: rtype = TYPE_CNAME;
          default: rtype = $urandom_range(0, 65535);
        endcase
        put16(rtype);
        put16(1);
        put16($urandom);
        put16($urandom);
        if (rtype == TYPE_A && $urandom_range(7) != 0) begin
          put16(4);
          for (int k = 0; k < 4; k++) put8(8'($urandom));
        end else if (rtype == TYPE_A || rtype > TYPE_CNAME) begin
          rdlen = $urandom_range(0, 5);
          put16(rdlen);
          for (int k = 0; k < rdlen; k++) put8(8'($urandom));
        end else begin
          rdlen = pkt_bytes.size() + 2;
          put_name($urandom_range(1, 2));
          put16(0);
          rdlen = pkt_bytes.size() - rdlen;
          // Patch in the true rdata length ahead of the name.
          pkt_bytes.delete(pkt_bytes.size() - 1);
          pkt_bytes.delete(pkt_bytes.size() - 1);
          pkt_bytes.insert(rdlen >= 0 ? pkt_bytes.size() - rdlen : 0, rdlen[7:0]);
          pkt_bytes.insert(pkt_bytes.size() - rdlen - 1, rdlen[15:8]);
        end
      end
    end
    // Noise: cut the packet or flip a byte now and then.
    cut = $urandom_range(9);
    if (cut == 0 && pkt_bytes.size() > 2)
      repeat ($urandom_range(1, pkt_bytes.size() - 1)) pkt_bytes.pop_back();
    else if (cut == 1)
      pkt_bytes[$urandom_range(pkt_bytes.size() - 1)] = 8'($urandom);
  endtask

  // Parse plus a few expands at offsets inside the current packet.
  task automatic exercise_packet();
    int n;
    n = pkt_bytes.size();
    send_beat(OP_PARSE, 8'($urandom), 1'($urandom), 9'($urandom));
    repeat ($urandom_range(1, 3))
      send_beat(OP_EXPAND, 8'($urandom), 1'($urandom),
                9'(n > 0 ? $urandom_range(0, n - 1) : 0));
  endtask

  task automatic wait_quiet();
    drop_valid();
    while (pending_count != 0) @(negedge clk);
    // Loads give no result, so the block may still be busy on a walk.
    repeat (2000) @(negedge clk);
  endtask

  task automatic write_limit(logic [3:0] v);
    config_write <= 1;
    config_data <= v;
    @(negedge clk);
    config_write <= 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: an empty store and a short packet both report status short.
    send_beat(OP_PARSE, 0, 0, 0);
    pkt_bytes = '{8'h00, 8'hFF, 8'h80};
    load_packet();
    send_beat(OP_PARSE, 0, 0, 0);
    send_beat(OP_EXPAND, 0, 0, 0);
    // An unused operation code is simply ignored.
    send_beat(2'd3, 8'hFF, 1, 9'h1FF);

    // A pointer loop tests the hop cap at a limit of one and of fifteen.
    wait_quiet();
    write_limit(4'd1);
    pkt_bytes = '{8'h01, 8'h41, 8'hC0, 8'h00, 8'h7F, 8'hC1};
    load_packet();
    send_beat(OP_EXPAND, 0, 0, 0);
    send_beat(OP_EXPAND, 0, 0, 9'd4);
    send_beat(OP_EXPAND, 0, 0, 9'd5);
    wait_quiet();
    write_limit(4'd15);
    send_beat(OP_EXPAND, 0, 0, 0);
    send_beat(OP_EXPAND, 0, 0, 9'd2);

    // A long label that points back to itself spells a name well past the
    // text buffer, so the expansion comes back truncated.
    pkt_bytes.delete();
    put8(8'd63);
    for (int i = 0; i < 63; i++) put8(8'h61 + 8'(i % 26));
    put8(8'hC0);
    put8(8'h00);
    load_packet();
    send_beat(OP_EXPAND, 0, 0, 0);
    send_beat(OP_PARSE, 0, 0, 0);
    send_beat(OP_EXPAND, 0, 0, 9'd64);

    wait_quiet();
    write_limit(4'd10);

    // Random phases with different idle patterns.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle = 49;
        recv_idle = 13;
      end else if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      while (items < 110 * (phase + 1)) begin
        build_response();
        load_packet();
        exercise_packet();
        if ($urandom_range(5) == 0) begin
          // Pause until all results are in.
          drop_valid();
          while (pending_count != 0) @(negedge clk);
        end
      end
      // Long receiver hold-off while the sender keeps offering work.
      fork
        begin
          hold_receiver = 1;
          repeat (400) @(negedge clk);
          hold_receiver = 0;
        end
        begin
          repeat (4) exercise_packet();
          drop_valid();
        end
      join
      wait_quiet();
      write_limit(phase == 0 ? 4'd15 : 4'($urandom_range(1, 15)));
    end

    wait_quiet();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
rtl/core/dnsrre_pkg.sv
rtl/core/dns_response_record_extractor.sv
tb/dns_record_checker.sv
tb/tb_dns_response_record_extractor.sv
